// ----- design/drt_pkg.sv -----
// Shared types, codes and constants for the divider/reload timer.
// Standalone package; used by divider_reload_timer.
package drt_pkg;

    localparam int DEF_MAX_TICK_CYCLES = 63;
    localparam int DEF_DIV_PERIOD      = 61;

    localparam int CLOCK_HZ = 1000000;
    localparam int PRESCALE_W = 9;   // signed prescaler width

    localparam logic [PRESCALE_W-1:0] PERIOD_R0 = PRESCALE_W'(CLOCK_HZ / 4096);
    localparam logic [PRESCALE_W-1:0] PERIOD_R1 = PRESCALE_W'(CLOCK_HZ / 262144);
    localparam logic [PRESCALE_W-1:0] PERIOD_R2 = PRESCALE_W'(CLOCK_HZ / 65536);
    localparam logic [PRESCALE_W-1:0] PERIOD_R3 = PRESCALE_W'(CLOCK_HZ / 16384);

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // register select codes
    localparam logic [1:0] SEL_DIV  = 2'd0;
    localparam logic [1:0] SEL_CNT  = 2'd1;
    localparam logic [1:0] SEL_MOD  = 2'd2;
    localparam logic [1:0] SEL_CTRL = 2'd3;

    localparam int CTRL_ENABLE_BIT = 3;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic [5:0] cycles;
    } drt_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_interrupt;
    } drt_out_t;

    function automatic logic [PRESCALE_W-1:0] rate_period(input logic [1:0] rate);
        logic [PRESCALE_W-1:0] p;
        case (rate)
            2'd0:    p = PERIOD_R0;
            2'd1:    p = PERIOD_R1;
            2'd2:    p = PERIOD_R2;
            default: p = PERIOD_R3;
        endcase
        return p;
    endfunction

endpackage

// ----- design/divider_reload_timer.sv -----
// Divider/reload timer: input register, single-pass update, result register.
// Depends on drt_pkg for transaction types, codes and rate periods.
// An accepted transaction's result enters the result register on advance.
// Throughput: one transaction per cycle unless a full result register waits on
// out_ready; the state update is one pass of small adds/compares in between.
// Reset: divider, counter, modulo cleared; counter stopped, rate 0 (period
// 244), divider prescaler loaded with DIV_PERIOD; pipeline emptied.
module divider_reload_timer #(
    parameter int MAX_TICK_CYCLES = drt_pkg::DEF_MAX_TICK_CYCLES,
    parameter int DIV_PERIOD      = drt_pkg::DEF_DIV_PERIOD
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  drt_pkg::drt_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output drt_pkg::drt_out_t out_data
);
    import drt_pkg::*;

    localparam int PW = PRESCALE_W;
    localparam logic signed [PW:0] FLOOR = -(PW+1)'(256);

    logic     s1_valid_reg;
    drt_in_t  s1_item_reg;
    logic     out_valid_reg;
    drt_out_t out_item_reg;

    logic [7:0]    div_val_reg, div_val_next;
    logic [PW-1:0] div_left_reg, div_left_next;
    logic [7:0]    cnt_val_reg, cnt_val_next;
    logic [7:0]    mod_val_reg, mod_val_next;
    logic          stopped_reg, stopped_next;
    logic [1:0]    rate_reg, rate_next;
    logic [PW-1:0] cnt_left_reg, cnt_left_next;

    drt_out_t result_next;
    logic     advance;

    logic [7:0]           amount;
    logic signed [PW:0]   div_dec, cnt_dec;
    logic [PW-1:0]        div_cl, cnt_cl;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        div_val_next  = div_val_reg;
        div_left_next = div_left_reg;
        cnt_val_next  = cnt_val_reg;
        mod_val_next  = mod_val_reg;
        stopped_next  = stopped_reg;
        rate_next     = rate_reg;
        cnt_left_next = cnt_left_reg;
        result_next   = '0;

        if ({2'b00, s1_item_reg.cycles} > 8'(MAX_TICK_CYCLES))
            amount = 8'(MAX_TICK_CYCLES);
        else
            amount = {2'b00, s1_item_reg.cycles};

        // count down with saturation at the floor
        div_dec = $signed({div_left_reg[PW-1], div_left_reg}) - $signed({2'b00, amount});
        div_cl  = (div_dec < FLOOR) ? FLOOR[PW-1:0] : div_dec[PW-1:0];
        cnt_dec = $signed({cnt_left_reg[PW-1], cnt_left_reg}) - $signed({2'b00, amount});
        if (stopped_reg)
            cnt_cl = cnt_left_reg;
        else
            cnt_cl = (cnt_dec < FLOOR) ? FLOOR[PW-1:0] : cnt_dec[PW-1:0];

        case (s1_item_reg.action)
            ACT_TICK:
            begin
                div_left_next = div_cl;
                if ($signed(div_cl) <= 0)
                begin
                    div_val_next  = div_val_reg + 8'd1;
                    div_left_next = div_cl + PW'(DIV_PERIOD);
                end
                cnt_left_next = cnt_cl;
                if ($signed(cnt_cl) <= 0)
                begin
                    if (cnt_val_reg == 8'hff)
                    begin
                        cnt_val_next = mod_val_reg;
                        result_next.timer_interrupt = 1'b1;
                    end
                    else
                        cnt_val_next = cnt_val_reg + 8'd1;
                    cnt_left_next = cnt_cl + rate_period(rate_reg);
                end
            end
            ACT_READ:
            begin
                case (s1_item_reg.reg_select)
                    SEL_DIV: result_next.read_data = div_val_reg;
                    SEL_CNT: result_next.read_data = cnt_val_reg;
                    SEL_MOD: result_next.read_data = mod_val_reg;
                    default: result_next.read_data = {4'b0000, !stopped_reg, 1'b0, rate_reg};
                endcase
            end
            ACT_WRITE:
            begin
                case (s1_item_reg.reg_select)
                    SEL_DIV: div_val_next = 8'd0;
                    SEL_CNT: cnt_val_next = s1_item_reg.write_data;
                    SEL_MOD: mod_val_next = s1_item_reg.write_data;
                    default:
                    begin
                        stopped_next = !s1_item_reg.write_data[CTRL_ENABLE_BIT];
                        rate_next    = s1_item_reg.write_data[1:0];
                    end
                endcase
            end
            default: ;  // unknown action: no effect
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            div_val_reg   <= 8'd0;
            div_left_reg  <= PW'(DIV_PERIOD);
            cnt_val_reg   <= 8'd0;
            mod_val_reg   <= 8'd0;
            stopped_reg   <= 1'b1;
            rate_reg      <= 2'd0;
            cnt_left_reg  <= rate_period(2'd0);
        end
        else
        begin
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                div_val_reg  <= div_val_next;
                div_left_reg <= div_left_next;
                cnt_val_reg  <= cnt_val_next;
                mod_val_reg  <= mod_val_next;
                stopped_reg  <= stopped_next;
                rate_reg     <= rate_next;
                cnt_left_reg <= cnt_left_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_data;
        if (advance)
            out_item_reg <= result_next;
    end

    // overflow reloads the counter from modulo
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.timer_interrupt |=> cnt_val_reg == $past(mod_val_reg))
        else $error("counter not reloaded from modulo on overflow");

    // any divider write clears the divider
    a_div_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.action == ACT_WRITE && s1_item_reg.reg_select == SEL_DIV
        |=> div_val_reg == 8'd0)
        else $error("divider not cleared by write");

    // an empty result register never blocks the input side
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // interrupt and read data are never both set
    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.timer_interrupt |-> out_item_reg.read_data == 8'd0)
        else $error("interrupt result carries read data");

endmodule
